// ===== rtl/core/bdct_pkg.sv =====
// Shared types and constants of the binned depth correction table.
// Used by the channel interfaces and by the top level; depends on nothing.
package bdct_pkg;

  typedef enum logic [1:0] {
    OP_READ = 2'd0,
    OP_ACC  = 2'd1,
    OP_HIT  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_TILE_SHIFT  = 2'd0,
    REG_DEPTH_SHIFT = 2'd1,
    REG_LAYERS      = 2'd2
  } reg_idx_t;

  localparam int SUM_W   = 40;
  localparam int HITS_W  = 24;
  localparam int Q_W     = 16;
  localparam int CFG_W   = 6;

  localparam logic [Q_W-1:0]    ONE_Q14   = 16'd16384;
  localparam logic [SUM_W-1:0]  SUM_RESET = 40'd16384;
  localparam logic [HITS_W-1:0] HITS_RESET = 24'd1;

  localparam logic [2:0] TILE_SHIFT_RESET  = 3'd3;
  localparam logic [3:0] DEPTH_SHIFT_RESET = 4'd6;
  localparam logic [5:0] LAYERS_RESET      = 6'd32;

endpackage

// ===== rtl/core/bdct_if.sv =====
// Request and result channel interfaces of the depth correction table.
// Depends on bdct_pkg for the width of the correction field.
interface bdct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [10:0] pixel_row;
  logic [11:0] pixel_col;
  logic [15:0] depth;
  logic [15:0] multiplier;

  modport source (output valid, op, pixel_row, pixel_col, depth, multiplier, input ready);
  modport sink   (input valid, op, pixel_row, pixel_col, depth, multiplier, output ready);
endinterface

interface bdct_out_if;
  logic                     valid;
  logic                     ready;
  logic [bdct_pkg::Q_W-1:0] correction;
  logic                     out_of_range;

  modport source (output valid, correction, out_of_range, input ready);
  modport sink   (input valid, correction, out_of_range, output ready);
endinterface

// ===== rtl/core/binned_depth_correction_table.sv =====
// Binned depth correction table: bin lookup, read-modify-write and serial divider.
// Depends on bdct_pkg and on the channel interfaces in bdct_if.sv.
// A read that runs the divider passes bin lookup, address, memory read, check, the
// 16-step restoring divider and the finish step; a saturating read or a write skips the
// divider, an out-of-range request goes from bin lookup to finish, and a held result
// stalls the finish step. A new request is taken only after the last has left finish.
// Reset is synchronous; a clearing pass over all LAYERS*TILE_ROWS*TILE_COLS bins (65536 by
// default) then loads every bin with sum 1.0 and one hit, with in_req.ready low meanwhile.
module binned_depth_correction_table #(
  parameter int LAYERS    = 32,
  parameter int TILE_ROWS = 32,
  parameter int TILE_COLS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bdct_in_if.sink                    in_req,
  bdct_out_if.source                 out_rsp,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bdct_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int BIN_COUNT = LAYERS * TILE_ROWS * TILE_COLS;
  localparam int ADDR_W    = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int MEM_W     = bdct_pkg::SUM_W + bdct_pkg::HITS_W;
  localparam int SW        = bdct_pkg::SUM_W;
  localparam int HW        = bdct_pkg::HITS_W;
  localparam int QW        = bdct_pkg::Q_W;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_LOC   = 8'b0000_0100,
    ST_MADDR = 8'b0000_1000,
    ST_RD    = 8'b0001_0000,
    ST_CHK   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [2:0] tile_shift_r;
  logic [3:0] depth_shift_r;
  logic [5:0] layers_r;

  // Request and working registers.
  bdct_pkg::op_t     op_r, op_nxt;
  logic [15:0]       mult_r, mult_nxt;
  logic [15:0]       z_r, z_nxt;
  logic [10:0]       y_r, y_nxt;
  logic [11:0]       x_r, x_nxt;
  logic              ok_r, ok_nxt;
  logic [ADDR_W-1:0] row_idx_r, row_idx_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [HW-1:0]     rem_r, rem_nxt;
  logic [QW-1:0]     low_r, low_nxt;
  logic [QW-1:0]     corr_r, corr_nxt;
  logic [3:0]        div_cnt_r, div_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [QW-1:0]     out_corr_r, out_corr_nxt;
  logic              out_oor_r, out_oor_nxt;

  // Memory and its ports.
  logic [MEM_W-1:0]  mem [BIN_COUNT];
  logic [MEM_W-1:0]  rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;

  logic [SW-1:0] rd_sum;
  logic [HW-1:0] rd_hits;
  logic [SW:0]   acc_sum;
  logic [HW:0]   trial;
  logic          in_fire;

  assign rd_sum  = rd_data_r[MEM_W-1:HW];
  assign rd_hits = rd_data_r[HW-1:0];
  assign acc_sum = {1'b0, rd_sum} + (SW + 1)'(mult_r);
  assign trial   = {rem_r, low_r[QW-1]};

  assign in_req.ready       = (state_r == ST_IDLE);
  assign in_fire            = in_req.valid && in_req.ready;
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.correction = out_corr_r;
  assign out_rsp.out_of_range = out_oor_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    mult_nxt      = mult_r;
    z_nxt         = z_r;
    y_nxt         = y_r;
    x_nxt         = x_r;
    ok_nxt        = ok_r;
    row_idx_nxt   = row_idx_r;
    addr_nxt      = addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    corr_nxt      = corr_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_corr_nxt  = out_corr_r;
    out_oor_nxt   = out_oor_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = rd_data_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = {bdct_pkg::SUM_RESET, bdct_pkg::HITS_RESET};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(BIN_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt    = bdct_pkg::op_t'(in_req.op);
          mult_nxt  = in_req.multiplier;
          z_nxt     = in_req.depth >> depth_shift_r;
          y_nxt     = in_req.pixel_row >> tile_shift_r;
          x_nxt     = in_req.pixel_col >> tile_shift_r;
          state_nxt = ST_LOC;
        end
      end
      ST_LOC: begin
        ok_nxt = (z_r < {10'b0, layers_r}) && (z_r < 16'(LAYERS)) &&
                 ({5'b0, y_r} < 16'(TILE_ROWS)) && ({4'b0, x_r} < 16'(TILE_COLS));
        row_idx_nxt = ADDR_W'(z_r) * ADDR_W'(TILE_ROWS) + ADDR_W'(y_r);
        if (ok_nxt) begin
          state_nxt = ST_MADDR;
        end else begin
          corr_nxt  = (op_r == bdct_pkg::OP_READ) ? bdct_pkg::ONE_Q14 : '0;
          state_nxt = ST_FIN;
        end
      end
      ST_MADDR: begin
        addr_nxt  = row_idx_r * ADDR_W'(TILE_COLS) + ADDR_W'(x_r);
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        corr_nxt  = '0;
        state_nxt = ST_FIN;
        case (op_r)
          bdct_pkg::OP_READ: begin
            // A quotient of 2^16 or more saturates; zero hits lands here too.
            if (rd_sum >= {rd_hits, {QW{1'b0}}}) begin
              corr_nxt = '1;
            end else begin
              rem_nxt     = rd_sum[SW-1:QW];
              low_nxt     = rd_sum[QW-1:0];
              div_cnt_nxt = 4'd15;
              state_nxt   = ST_DIV;
            end
          end
          bdct_pkg::OP_ACC: begin
            mem_we    = 1'b1;
            mem_wdata = {(acc_sum[SW] ? {SW{1'b1}} : acc_sum[SW-1:0]), rd_hits};
          end
          bdct_pkg::OP_HIT: begin
            mem_we    = 1'b1;
            mem_wdata = {rd_sum, (&rd_hits) ? rd_hits : rd_hits + 1'b1};
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        // Restoring step; the remainder always stays below the hit count.
        low_nxt = {low_r[QW-2:0], 1'b0};
        if (trial >= {1'b0, rd_hits}) begin
          rem_nxt  = HW'(trial - {1'b0, rd_hits});
          corr_nxt = {corr_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt  = trial[HW-1:0];
          corr_nxt = {corr_r[QW-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == 4'd0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_corr_nxt  = corr_r;
          out_oor_nxt   = !ok_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      ok_r          <= 1'b0;
      tile_shift_r  <= bdct_pkg::TILE_SHIFT_RESET;
      depth_shift_r <= bdct_pkg::DEPTH_SHIFT_RESET;
      layers_r      <= bdct_pkg::LAYERS_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ok_r        <= ok_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bdct_pkg::REG_TILE_SHIFT:  tile_shift_r  <= cfg_wdata[2:0];
          bdct_pkg::REG_DEPTH_SHIFT: depth_shift_r <= cfg_wdata[3:0];
          bdct_pkg::REG_LAYERS:      layers_r      <= cfg_wdata[5:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mult_r     <= mult_nxt;
    z_r        <= z_nxt;
    y_r        <= y_nxt;
    x_r        <= x_nxt;
    row_idx_r  <= row_idx_nxt;
    addr_r     <= addr_nxt;
    rem_r      <= rem_nxt;
    low_r      <= low_nxt;
    corr_r     <= corr_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_corr_r <= out_corr_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  // Single-port bin memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == ST_RD) begin
      rd_data_r <= mem[addr_r];
    end
  end

  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the finish step");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR) || ((state_r == ST_CHK) && ok_r))
    else $error("bin written outside the clear pass or for an out-of-range request");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < rd_hits))
    else $error("divider remainder not below hit count");

  a_oor_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_corr_r == bdct_pkg::ONE_Q14) || (out_corr_r == '0))
    else $error("out-of-range result carries a table value");

  a_after_reset: assert property (@(posedge clk)
    !rst_n |=> (state_r == ST_CLEAR) && !out_valid_r)
    else $error("reset did not start the clearing pass");

endmodule
